// File: src/ray_unit_cube_intersect_top_macros.svh
// Assertion macros for the ray / unit cube intersection block.
// Included by the top level; depends on nothing else.
`ifndef RAY_UNIT_CUBE_INTERSECT_TOP_MACROS_SVH
`define RAY_UNIT_CUBE_INTERSECT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RUCX_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("rucx: assertion failed");
`define RUCX_ASSERT_AFTER(lbl, clk, rstn, pre, n, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> ## (n) (post)) \
    else $error("rucx: assertion failed");
`else
`define RUCX_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define RUCX_ASSERT_AFTER(lbl, clk, rstn, pre, n, post)
`endif
`endif

// File: src/rucx_pkg.sv
// Shared types and constants of the ray / unit cube intersection block.
// No dependencies.
package rucx_pkg;

  localparam int TestLat = 6;   // sphere test and face span test depth
  localparam int DivLat  = 34;  // divider depth, input to output register

  localparam logic signed [31:0] TNoHit = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } rucx_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_hit;
    logic [1:0]         faces_found;
  } rucx_out_t;

  // Face k = 2*pair + side; pairs in order z, x, y; side 0 is the + face.
  typedef struct packed {
    logic [5:0]       hit;
    logic [5:0][32:0] num;   // signed plane - eye per face
    logic [2:0][31:0] dmag;  // |dir| on the pair's axis
    logic [2:0]       dneg;  // dir sign on the pair's axis
  } rucx_face_t;

  typedef struct packed {
    logic [63:0] n;    // |num| << frac bits
    logic [31:0] d;    // |dir|
    logic        neg;  // quotient sign
  } rucx_div_in_t;

endpackage

// File: src/rucx_reject.sv
// Bounding sphere rejection: |eye x dir|^2 <= 0.75 * |dir|^2, six stages.
// Depends on rucx_pkg.
module rucx_reject #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  rucx_pkg::rucx_in_t ray_i,
  output logic              ok_o
);
  import rucx_pkg::*;

  logic signed [31:0]  e [3];
  logic signed [31:0]  d [3];
  logic [31:0]         dm [3];
  logic signed [63:0]  prod1_q [6];
  logic [63:0]         dsq1_q [3];
  logic signed [64:0]  v [3];
  logic [63:0]         m [3];
  logic [63:0]         mag2_q [3];
  logic [63:0]         dd2_q;
  logic [63:0]         hh3_q [3];
  logic [63:0]         hl3_q [3];
  logic [63:0]         ll3_q [3];
  logic [127:0]        rhs3_q, rhs4_q, rhs5_q;
  logic [127:0]        sq4_q [3];
  logic [127:0]        s01_q, sq2_q;
  logic                ok_q;

  always_comb begin
    e[0] = ray_i.eye_x; e[1] = ray_i.eye_y; e[2] = ray_i.eye_z;
    d[0] = ray_i.dir_x; d[1] = ray_i.dir_y; d[2] = ray_i.dir_z;
    for (int k = 0; k < 3; k++) begin
      dm[k] = d[k][31] ? -d[k] : d[k];
    end
  end

  // stage 1: cross product terms, squared direction parts
  always_ff @(posedge clk_i) begin
    prod1_q[0] <= 64'(e[1]) * 64'(d[2]);
    prod1_q[1] <= 64'(e[2]) * 64'(d[1]);
    prod1_q[2] <= 64'(e[2]) * 64'(d[0]);
    prod1_q[3] <= 64'(e[0]) * 64'(d[2]);
    prod1_q[4] <= 64'(e[0]) * 64'(d[1]);
    prod1_q[5] <= 64'(e[1]) * 64'(d[0]);
    for (int k = 0; k < 3; k++) begin
      dsq1_q[k] <= 64'(dm[k]) * 64'(dm[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k] = 65'(prod1_q[2*k]) - 65'(prod1_q[2*k+1]);
      m[k] = v[k][64] ? 64'(-v[k]) : 64'(v[k]);
    end
  end

  // stage 2: cross magnitudes, |dir|^2
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mag2_q[k] <= m[k];
    end
    dd2_q <= dsq1_q[0] + dsq1_q[1] + dsq1_q[2];
  end

  // stage 3: 32x32 partial products of the squares
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      hh3_q[k] <= 64'(mag2_q[k][63:32]) * 64'(mag2_q[k][63:32]);
      hl3_q[k] <= 64'(mag2_q[k][63:32]) * 64'(mag2_q[k][31:0]);
      ll3_q[k] <= 64'(mag2_q[k][31:0]) * 64'(mag2_q[k][31:0]);
    end
    rhs3_q <= ((128'(dd2_q) << 1) + 128'(dd2_q)) << (2 * FRAC_BITS - 2);
  end

  // stage 4: assemble squares
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq4_q[k] <= (128'(hh3_q[k]) << 64) + (128'(hl3_q[k]) << 33) + 128'(ll3_q[k]);
    end
    rhs4_q <= rhs3_q;
  end

  // stage 5/6: sum and compare
  always_ff @(posedge clk_i) begin
    s01_q  <= sq4_q[0] + sq4_q[1];
    sq2_q  <= sq4_q[2];
    rhs5_q <= rhs4_q;
    ok_q   <= (s01_q + sq2_q) <= rhs5_q;
  end

  assign ok_o = ok_q;

endmodule

// File: src/rucx_span.sv
// Face span tests for the six cube faces, six stages to match rucx_reject.
// Depends on rucx_pkg.
module rucx_span #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  rucx_pkg::rucx_in_t   ray_i,
  output rucx_pkg::rucx_face_t face_o
);
  import rucx_pkg::*;

  localparam logic signed [32:0] Half = 33'sd1 << (FRAC_BITS - 1);
  // pair order z, x, y with the two other axes
  localparam logic [2:0][1:0] Axis = {2'd1, 2'd0, 2'd2};
  localparam logic [2:0][1:0] Oth1 = {2'd0, 2'd1, 2'd0};
  localparam logic [2:0][1:0] Oth2 = {2'd2, 2'd2, 2'd1};

  logic signed [31:0] e [3];
  logic signed [31:0] d [3];

  logic signed [32:0] num1_q [3][2];
  logic signed [32:0] num2_q [3][2];
  logic signed [32:0] num3_q [3][2];
  logic signed [32:0] num4_q [3][2];
  logic signed [63:0] ebda1_q [3][2];
  logic signed [63:0] ebda2_q [3][2];
  logic signed [31:0] db1_q [3][2];
  logic signed [64:0] dbnum2_q [3][2][2];
  logic signed [66:0] w3_q [3][2][2];
  logic [63:0]        lim3_q [3];
  logic [31:0]        dmag1_q [3];
  logic [31:0]        dmag2_q [3];
  logic [31:0]        dmag3_q [3];
  logic [31:0]        dmag4_q [3];
  logic               dneg1_q [3];
  logic               dneg2_q [3];
  logic               dneg3_q [3];
  logic               dneg4_q [3];
  logic               dnz1_q [3];
  logic               dnz2_q [3];
  logic               dnz3_q [3];
  logic               hit4_q [3][2];
  rucx_face_t         face4, face5_q, face6_q;

  always_comb begin
    e[0] = ray_i.eye_x; e[1] = ray_i.eye_y; e[2] = ray_i.eye_z;
    d[0] = ray_i.dir_x; d[1] = ray_i.dir_y; d[2] = ray_i.dir_z;
  end

  for (genvar p = 0; p < 3; p++) begin : g_pair
    localparam int A = int'(Axis[p]);
    localparam int B = int'(Oth1[p]);
    localparam int C = int'(Oth2[p]);
    logic signed [66:0] lim_s;

    assign lim_s = $signed(67'(lim3_q[p]));

    always_ff @(posedge clk_i) begin
      // stage 1: plane offsets and eye * dir terms
      dmag1_q[p]    <= d[A][31] ? -d[A] : d[A];
      dneg1_q[p]    <= d[A][31];
      dnz1_q[p]     <= d[A] != '0;
      ebda1_q[p][0] <= 64'(e[B]) * 64'(d[A]);
      ebda1_q[p][1] <= 64'(e[C]) * 64'(d[A]);
      db1_q[p][0]   <= d[B];
      db1_q[p][1]   <= d[C];
      num1_q[p][0]  <= Half - 33'(e[A]);
      num1_q[p][1]  <= -Half - 33'(e[A]);
      // stage 2: dir * offset terms
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < 2; j++) begin
          dbnum2_q[p][s][j] <= 65'(db1_q[p][j]) * 65'(num1_q[p][s]);
        end
        num2_q[p][s] <= num1_q[p][s];
      end
      ebda2_q[p] <= ebda1_q[p];
      dmag2_q[p] <= dmag1_q[p];
      dneg2_q[p] <= dneg1_q[p];
      dnz2_q[p]  <= dnz1_q[p];
      // stage 3: scaled crossing coordinate and bound
      for (int s = 0; s < 2; s++) begin
        for (int j = 0; j < 2; j++) begin
          w3_q[p][s][j] <= 67'(ebda2_q[p][j]) + 67'(dbnum2_q[p][s][j]);
        end
        num3_q[p][s] <= num2_q[p][s];
      end
      lim3_q[p]  <= 64'(dmag2_q[p]) << (FRAC_BITS - 1);
      dmag3_q[p] <= dmag2_q[p];
      dneg3_q[p] <= dneg2_q[p];
      dnz3_q[p]  <= dnz2_q[p];
      // stage 4: bounds check, bounds included
      for (int s = 0; s < 2; s++) begin
        hit4_q[p][s] <= dnz3_q[p]
                     && (w3_q[p][s][0] <= lim_s) && (w3_q[p][s][0] >= -lim_s)
                     && (w3_q[p][s][1] <= lim_s) && (w3_q[p][s][1] >= -lim_s);
        num4_q[p][s] <= num3_q[p][s];
      end
      dmag4_q[p] <= dmag3_q[p];
      dneg4_q[p] <= dneg3_q[p];
    end
  end

  always_comb begin
    face4 = '0;
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 2; s++) begin
        face4.hit[2*p+s] = hit4_q[p][s];
        face4.num[2*p+s] = num4_q[p][s];
      end
      face4.dmag[p] = dmag4_q[p];
      face4.dneg[p] = dneg4_q[p];
    end
  end

  // stages 5/6: align with the sphere test
  always_ff @(posedge clk_i) begin
    face5_q <= face4;
    face6_q <= face5_q;
  end

  assign face_o = face6_q;

endmodule

// File: src/rucx_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating to 32 bits.
// Depends on rucx_pkg.
module rucx_div (
  input  logic                  clk_i,
  input  rucx_pkg::rucx_div_in_t div_i,
  output logic signed [31:0]    t_o
);
  import rucx_pkg::*;

  logic [31:0]        r_q   [33];
  logic [31:0]        nl_q  [33];
  logic [31:0]        q_q   [33];
  logic [31:0]        d_q   [33];
  logic               neg_q [33];
  logic               ovf_q [33];
  logic               big;
  logic signed [31:0] t_q;

  // quotient of 2^32 or more cannot fit: flag it up front
  always_ff @(posedge clk_i) begin
    r_q[0]   <= div_i.n[63:32];
    nl_q[0]  <= div_i.n[31:0];
    q_q[0]   <= '0;
    d_q[0]   <= div_i.d;
    neg_q[0] <= div_i.neg;
    ovf_q[0] <= div_i.n[63:32] >= div_i.d;
  end

  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [32:0] trial;
    logic        fits;

    assign trial = {r_q[i], nl_q[i][31]};
    assign fits  = trial >= {1'b0, d_q[i]};

    always_ff @(posedge clk_i) begin
      r_q[i+1]   <= fits ? 32'(trial - {1'b0, d_q[i]}) : trial[31:0];
      q_q[i+1]   <= {q_q[i][30:0], fits};
      nl_q[i+1]  <= {nl_q[i][30:0], 1'b0};
      d_q[i+1]   <= d_q[i];
      neg_q[i+1] <= neg_q[i];
      ovf_q[i+1] <= ovf_q[i];
    end
  end

  assign big = ovf_q[32] || q_q[32][31];

  always_ff @(posedge clk_i) begin
    if (neg_q[32]) begin
      t_q <= big ? 32'sh8000_0000 : -$signed(q_q[32]);
    end else begin
      t_q <= big ? TNoHit : $signed(q_q[32]);
    end
  end

  assign t_o = t_q;

endmodule

// File: src/ray_unit_cube_intersect_top.sv
// Ray against the origin-centered cube of half size 0.5, signed fixed point.
// A result strobes on done_o, with res_o, once the ray has passed the test stages, the select register and the divider.
// Throughput: one ray per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 32-step quotient divider (34 stages) after the test stages and a select register.
// Reset (async, active low) clears only the valid line; data regs are not reset.
// Uses rucx_pkg, rucx_reject, rucx_span, rucx_div and the assertion macro header.
`include "ray_unit_cube_intersect_top_macros.svh"
module ray_unit_cube_intersect_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rucx_pkg::rucx_in_t   in_i,
  output logic                done_o,
  output rucx_pkg::rucx_out_t  res_o
);
  import rucx_pkg::*;

  localparam int PipeLat = TestLat + 1 + DivLat;

  logic               accept;
  logic [PipeLat-1:0] v_q;
  logic               done_q;

  logic               ok;
  rucx_face_t         face;
  logic [5:0]         hits;
  logic [2:0]         idx [2];
  logic [1:0]         cnt;
  logic signed [32:0] nsel [2];
  logic [32:0]        nabs [2];
  rucx_div_in_t       sel_d [2];
  rucx_div_in_t       sel_q [2];
  logic [1:0]         cnt_sel_q;
  logic [1:0]         cd_q [DivLat];
  logic signed [31:0] t0, t1;
  rucx_out_t          res_d, res_q;

  // never stalls; an item enters every cycle start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid line follows each beat through the whole pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_q <= 1'b0;
    end else begin
      v_q    <= {v_q[PipeLat-2:0], accept};
      done_q <= v_q[PipeLat-1];
    end
  end

  // sphere test and face span tests run side by side, same depth
  rucx_reject #(.FRAC_BITS(FRAC_BITS)) u_reject (
    .clk_i (clk_i),
    .ray_i (in_i),
    .ok_o  (ok)
  );

  rucx_span #(.FRAC_BITS(FRAC_BITS)) u_span (
    .clk_i  (clk_i),
    .ray_i  (in_i),
    .face_o (face)
  );

  // pick the first two hit faces in z+, z-, x+, x-, y+, y- order
  assign hits = ok ? face.hit : 6'b0;

  always_comb begin
    idx[0] = '0;
    idx[1] = '0;
    cnt    = '0;
    for (int k = 0; k < 6; k++) begin
      if (hits[k]) begin
        if (cnt == 2'd0) begin
          idx[0] = 3'(k);
        end else if (cnt == 2'd1) begin
          idx[1] = 3'(k);
        end
        if (cnt != 2'd2) begin
          cnt = cnt + 2'd1;
        end
      end
    end
    for (int j = 0; j < 2; j++) begin
      nsel[j]      = $signed(face.num[idx[j]]);
      nabs[j]      = nsel[j][32] ? 33'(-nsel[j]) : 33'(nsel[j]);
      sel_d[j].n   = 64'(nabs[j][31:0]) << FRAC_BITS;
      sel_d[j].d   = face.dmag[idx[j][2:1]];
      sel_d[j].neg = nsel[j][32] ^ face.dneg[idx[j][2:1]];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    cnt_sel_q <= cnt;
  end

  // t = (plane - eye) / dir, one divider per found face
  rucx_div u_div0 (
    .clk_i (clk_i),
    .div_i (sel_q[0]),
    .t_o   (t0)
  );

  rucx_div u_div1 (
    .clk_i (clk_i),
    .div_i (sel_q[1]),
    .t_o   (t1)
  );

  // hit count rides alongside the dividers
  always_ff @(posedge clk_i) begin
    cd_q[0] <= cnt_sel_q;
    for (int i = 1; i < DivLat; i++) begin
      cd_q[i] <= cd_q[i-1];
    end
  end

  always_comb begin
    res_d.faces_found = cd_q[DivLat-1];
    res_d.hit         = cd_q[DivLat-1] != 2'd0;
    case (cd_q[DivLat-1])
      2'd2:    res_d.t_hit = (t0 < t1) ? t0 : t1;
      2'd1:    res_d.t_hit = t0;
      default: res_d.t_hit = TNoHit;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // every accepted beat comes out on done_o; done_o is sampled at the edge ending its cycle
  `RUCX_ASSERT_AFTER(a_latency, clk_i, rst_ni, accept, PipeLat + 1, done_o)
  // hit flag agrees with the face count
  `RUCX_ASSERT_IMPL(a_hit_cnt, clk_i, rst_ni, done_o, res_o.hit == (res_o.faces_found != 2'd0))
  // a miss reports the saturated t
  `RUCX_ASSERT_IMPL(a_miss_t, clk_i, rst_ni, done_o && !res_o.hit, res_o.t_hit == TNoHit)

endmodule
